### rtl/snell_pkg.sv
// Package for the refraction unit: widths, stage counts, payload types, fixed-point helpers.
`default_nettype none

package snell_pkg;

    // Number format
    localparam int FRAC_BITS = 14;
    localparam int FLD_W     = 16;
    localparam int Q_W       = 32;
    localparam int IN_W      = 7 * FLD_W;
    localparam int OUT_W     = 3 * FLD_W;

    // Dot product sum and its rounded result
    localparam int SUM_W = 2 * FLD_W + 2;
    localparam int C_W   = SUM_W - FRAC_BITS;

    // Reciprocal of the index: 2^(2F) / ior, long division a few bits per stage
    localparam int ETA_QW  = 2 * FRAC_BITS + 1;
    localparam int ETA_PER = 4;
    localparam int ETA_ST  = (ETA_QW + ETA_PER - 1) / ETA_PER;

    // Square root of k << F
    localparam int SQK_N   = (Q_W + FRAC_BITS) / 2;
    localparam int SQK_RW  = 2 * SQK_N;
    localparam int SQK_PER = 3;
    localparam int SQK_ST  = (SQK_N + SQK_PER - 1) / SQK_PER;

    // Square root of the squared length
    localparam int LEN_N   = Q_W;
    localparam int LEN_RW  = 2 * LEN_N;
    localparam int LEN_PER = 2;
    localparam int LEN_ST  = (LEN_N + LEN_PER - 1) / LEN_PER;

    // Output division: 16 quotient bits per lane
    localparam int OD_N   = FLD_W;
    localparam int OD_NW  = Q_W + FRAC_BITS + 1;
    localparam int OD_PER = 2;
    localparam int OD_ST  = (OD_N + OD_PER - 1) / OD_PER;

    localparam logic [FLD_W:0]   OUT_LIM     = {2'b01, {(FLD_W - 1){1'b0}}};
    localparam logic [FLD_W-1:0] OUT_POS_MAX = {1'b0, {(FLD_W - 1){1'b1}}};

    localparam logic signed [Q_W-1:0] SAT_MAX = {1'b0, {(Q_W - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] SAT_MIN = {1'b1, {(Q_W - 1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_ONE   = Q_W'(1) << FRAC_BITS;
    localparam logic signed [Q_W-1:0] Q_HALF  = Q_W'(1) << (FRAC_BITS - 1);

    typedef logic signed [2*Q_W+3:0] wide_t;

    // Input capture with dot product terms
    typedef struct packed {
        logic                       vld;
        logic [2:0][FLD_W-1:0]      d;
        logic [2:0][FLD_W-1:0]      n;
        logic [FLD_W-1:0]           ior;
        logic [2:0][2*FLD_W-1:0]    p;
    } s1_t;

    // Reciprocal divider stage
    typedef struct packed {
        logic                       vld;
        logic [2:0][FLD_W-1:0]      d;
        logic [2:0][FLD_W:0]        n17;
        logic signed [C_W-1:0]      cpos;
        logic                       enter;
        logic [FLD_W-1:0]           ior;
        logic [ETA_QW-1:0]          num;
        logic [FLD_W-1:0]           rem;
        logic [ETA_QW-1:0]          quo;
    } ed_t;

    // k evaluation stages
    typedef struct packed {
        logic                       vld;
        logic signed [Q_W-1:0]      ee;
        logic signed [Q_W-1:0]      acc;
        logic signed [Q_W-1:0]      ec;
        logic [2:0][Q_W-1:0]        edd;
        logic [2:0][FLD_W:0]        n17;
    } cm_t;

    // sqrt(k) stage
    typedef struct packed {
        logic                       vld;
        logic signed [Q_W-1:0]      ec;
        logic [2:0][Q_W-1:0]        edd;
        logic [2:0][FLD_W:0]        n17;
        logic                       tir;
        logic [SQK_RW-1:0]          rad;
        logic [SQK_N+1:0]           rem;
        logic [SQK_N-1:0]           root;
    } sk_t;

    typedef struct packed {
        logic                       vld;
        logic signed [Q_W-1:0]      t;
        logic [2:0][Q_W-1:0]        edd;
        logic [2:0][FLD_W:0]        n17;
        logic                       tir;
    } e1_t;

    typedef struct packed {
        logic                       vld;
        logic [2:0][Q_W-1:0]        edd;
        logic [2:0][Q_W-1:0]        tn;
        logic                       tir;
    } e2_t;

    typedef struct packed {
        logic                       vld;
        logic [2:0][Q_W-1:0]        v;
        logic                       tir;
    } e3_t;

    typedef struct packed {
        logic                       vld;
        logic [2:0][Q_W-1:0]        v;
        logic [2:0][2*Q_W-1:0]      sq;
        logic                       tir;
    } e4_t;

    // Length sqrt stage
    typedef struct packed {
        logic                       vld;
        logic [2:0][Q_W-1:0]        v;
        logic                       tir;
        logic [LEN_RW-1:0]          rad;
        logic [LEN_N+1:0]           rem;
        logic [LEN_N-1:0]           root;
    } sl_t;

    // Output divider stage
    typedef struct packed {
        logic                       vld;
        logic                       tir;
        logic                       lzero;
        logic [LEN_N-1:0]           len;
        logic [2:0]                 neg;
        logic [2:0]                 ovf;
        logic [2:0][LEN_N-1:0]      rem;
        logic [2:0][OD_N-1:0]       low;
        logic [2:0][OD_N-1:0]       quo;
    } od_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [Q_W-1:0] sat32(input wide_t v);
        if (v > wide_t'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (v < wide_t'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return Q_W'(v);
    endfunction

    // Fixed-point product, rounded half up, saturated
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W:0] a,
                                                   input logic signed [Q_W:0] b);
        logic signed [2*Q_W+1:0] p;
        wide_t                   r;
        p = a * b;
        r = (wide_t'(p) + wide_t'(Q_HALF)) >>> FRAC_BITS;
        return sat32(r);
    endfunction

endpackage

`default_nettype wire

### rtl/snell_refraction_direction_unit.sv
// Pipelined Snell's-law refraction of a unit direction about a surface normal.
//
// Channel | Dir | tdata fields (low bit up)                              | tuser
// s_      | in  | dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, refr_index | -
// m_      | out | out_x, out_y, out_z                                    | total_reflect
//
// One ray per cycle, except while the pipeline is held as described below.
// Depth is set by the bit-serial chains: index reciprocal (4 bits/stage), sqrt(k)
// (3 steps/stage), length sqrt (2 steps/stage) and per-lane output division (2 bits/stage).
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
// The pipeline holds only while the last stage is full and the output register is
// held by the sink; otherwise bubbles keep draining and new rays are taken.
`default_nettype none

module snell_refraction_direction_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, refr_index
    input  logic [snell_pkg::IN_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_x, out_y, out_z
    output logic [snell_pkg::OUT_W-1:0] m_tdata,
    // total_reflect
    output logic                        m_tuser
);
    import snell_pkg::*;

    s1_t s1_reg, s1_next;
    ed_t ed_reg [0:ETA_ST];
    ed_t ed0_next;
    cm_t cm0_reg, cm0_next, cm1_reg, cm1_next, cm2_reg, cm2_next;
    sk_t sk_reg [0:SQK_ST];
    sk_t sk0_next;
    e1_t e1_reg, e1_next;
    e2_t e2_reg, e2_next;
    e3_t e3_reg, e3_next;
    e4_t e4_reg, e4_next;
    sl_t sl_reg [0:LEN_ST];
    sl_t sl0_next;
    od_t od_reg [0:OD_ST];
    od_t od0_next;

    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;
    logic               adv;

    // Hold only when the last stage has a ray and the output is blocked
    assign adv      = !(od_reg[OD_ST].vld && m_valid_reg && !m_tready);
    assign s_tready = adv;

    // Capture and dot product terms
    always_comb begin
        s1_next.vld = s_tvalid;
        for (int i = 0; i < 3; i++) begin
            s1_next.d[i] = s_tdata[FLD_W*i +: FLD_W];
            s1_next.n[i] = s_tdata[FLD_W*(3+i) +: FLD_W];
            s1_next.p[i] = (2*FLD_W)'($signed(s_tdata[FLD_W*i +: FLD_W])
                                      * $signed(s_tdata[FLD_W*(3+i) +: FLD_W]));
        end
        s1_next.ior = s_tdata[FLD_W*6 +: FLD_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
        end else if (adv) begin
            s1_reg <= s1_next;
        end
    end

    // Rounded dot product, direction of travel, divider setup
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        logic signed [C_W-1:0]   craw;
        logic signed [FLD_W:0]   ns;
        sum = SUM_W'($signed(s1_reg.p[0])) + SUM_W'($signed(s1_reg.p[1]))
            + SUM_W'($signed(s1_reg.p[2])) + SUM_W'(Q_HALF);
        craw = C_W'(sum >>> FRAC_BITS);
        ed0_next.vld   = s1_reg.vld;
        ed0_next.d     = s1_reg.d;
        ed0_next.enter = craw[C_W-1];
        ed0_next.cpos  = craw[C_W-1] ? -craw : craw;
        for (int i = 0; i < 3; i++) begin
            ns = (FLD_W+1)'($signed(s1_reg.n[i]));
            ed0_next.n17[i] = craw[C_W-1] ? ns : -ns;
        end
        ed0_next.ior = s1_reg.ior;
        ed0_next.num = (ETA_QW'(1) << (2*FRAC_BITS)) + ETA_QW'(s1_reg.ior >> 1);
        ed0_next.rem = '0;
        ed0_next.quo = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ed_reg[0].vld <= 1'b0;
        end else if (adv) begin
            ed_reg[0] <= ed0_next;
        end
    end

    // Restoring division for 1/ior, MSB first
    for (genvar g = 1; g <= ETA_ST; g++) begin : g_eta
        ed_t stage_next;
        always_comb begin
            logic [FLD_W:0] r;
            int             j;
            stage_next = ed_reg[g-1];
            for (int i = 0; i < ETA_PER; i++) begin
                j = ETA_QW - 1 - ((g - 1) * ETA_PER + i);
                if (j >= 0) begin
                    r = {stage_next.rem, stage_next.num[j]};
                    if (r >= {1'b0, stage_next.ior}) begin
                        r = r - {1'b0, stage_next.ior};
                        stage_next.quo[j] = 1'b1;
                    end
                    stage_next.rem = r[FLD_W-1:0];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ed_reg[g].vld <= 1'b0;
            end else if (adv) begin
                ed_reg[g] <= stage_next;
            end
        end
    end

    // eta select and the products that depend on it
    always_comb begin
        logic signed [Q_W-1:0] eta;
        if (ed_reg[ETA_ST].enter) begin
            eta = (ed_reg[ETA_ST].ior == '0) ? SAT_MAX : Q_W'(ed_reg[ETA_ST].quo);
        end else begin
            eta = Q_W'(ed_reg[ETA_ST].ior);
        end
        cm0_next.vld = ed_reg[ETA_ST].vld;
        cm0_next.ee  = qmul((Q_W+1)'(eta), (Q_W+1)'(eta));
        cm0_next.acc = qmul((Q_W+1)'(ed_reg[ETA_ST].cpos), (Q_W+1)'(ed_reg[ETA_ST].cpos));
        cm0_next.ec  = qmul((Q_W+1)'(eta), (Q_W+1)'(ed_reg[ETA_ST].cpos));
        for (int i = 0; i < 3; i++) begin
            cm0_next.edd[i] = qmul((Q_W+1)'(eta), (Q_W+1)'($signed(ed_reg[ETA_ST].d[i])));
        end
        cm0_next.n17 = ed_reg[ETA_ST].n17;
    end

    // 1 - c^2
    always_comb begin
        cm1_next     = cm0_reg;
        cm1_next.acc = sat32(wide_t'(Q_ONE) - wide_t'(cm0_reg.acc));
    end

    // eta^2 (1 - c^2)
    always_comb begin
        cm2_next     = cm1_reg;
        cm2_next.acc = qmul((Q_W+1)'(cm1_reg.ee), (Q_W+1)'(cm1_reg.acc));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cm0_reg.vld <= 1'b0;
            cm1_reg.vld <= 1'b0;
            cm2_reg.vld <= 1'b0;
        end else if (adv) begin
            cm0_reg <= cm0_next;
            cm1_reg <= cm1_next;
            cm2_reg <= cm2_next;
        end
    end

    // k, total reflection flag, radicand setup
    always_comb begin
        logic signed [Q_W-1:0] k;
        k = sat32(wide_t'(Q_ONE) - wide_t'(cm2_reg.acc));
        sk0_next.vld  = cm2_reg.vld;
        sk0_next.ec   = cm2_reg.ec;
        sk0_next.edd  = cm2_reg.edd;
        sk0_next.n17  = cm2_reg.n17;
        sk0_next.tir  = k[Q_W-1];
        sk0_next.rad  = k[Q_W-1] ? '0 : (SQK_RW'($unsigned(k)) << FRAC_BITS);
        sk0_next.rem  = '0;
        sk0_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sk_reg[0].vld <= 1'b0;
        end else if (adv) begin
            sk_reg[0] <= sk0_next;
        end
    end

    // Digit-by-digit sqrt of k << F
    for (genvar g = 1; g <= SQK_ST; g++) begin : g_sqk
        sk_t stage_next;
        always_comb begin
            logic [SQK_N+3:0] r;
            logic [SQK_N+3:0] trial;
            int               s;
            int               idx;
            stage_next = sk_reg[g-1];
            for (int i = 0; i < SQK_PER; i++) begin
                s = (g - 1) * SQK_PER + i;
                if (s < SQK_N) begin
                    idx   = SQK_N - 1 - s;
                    r     = {stage_next.rem, stage_next.rad[2*idx +: 2]};
                    trial = {2'b00, stage_next.root, 2'b01};
                    if (r >= trial) begin
                        r = r - trial;
                        stage_next.root = {stage_next.root[SQK_N-2:0], 1'b1};
                    end else begin
                        stage_next.root = {stage_next.root[SQK_N-2:0], 1'b0};
                    end
                    stage_next.rem = r[SQK_N+1:0];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sk_reg[g].vld <= 1'b0;
            end else if (adv) begin
                sk_reg[g] <= stage_next;
            end
        end
    end

    // Normal coefficient t = eta*c - sqrt(k)
    always_comb begin
        e1_next.vld = sk_reg[SQK_ST].vld;
        e1_next.t   = sat32(wide_t'(sk_reg[SQK_ST].ec) - wide_t'(sk_reg[SQK_ST].root));
        e1_next.edd = sk_reg[SQK_ST].edd;
        e1_next.n17 = sk_reg[SQK_ST].n17;
        e1_next.tir = sk_reg[SQK_ST].tir;
    end

    // t * n per lane
    always_comb begin
        e2_next.vld = e1_reg.vld;
        e2_next.edd = e1_reg.edd;
        e2_next.tir = e1_reg.tir;
        for (int i = 0; i < 3; i++) begin
            e2_next.tn[i] = qmul((Q_W+1)'(e1_reg.t), (Q_W+1)'($signed(e1_reg.n17[i])));
        end
    end

    // Unnormalized refracted vector
    always_comb begin
        e3_next.vld = e2_reg.vld;
        e3_next.tir = e2_reg.tir;
        for (int i = 0; i < 3; i++) begin
            e3_next.v[i] = sat32(wide_t'($signed(e2_reg.edd[i]))
                                 + wide_t'($signed(e2_reg.tn[i])));
        end
    end

    // Squares per lane
    always_comb begin
        e4_next.vld = e3_reg.vld;
        e4_next.v   = e3_reg.v;
        e4_next.tir = e3_reg.tir;
        for (int i = 0; i < 3; i++) begin
            e4_next.sq[i] = (2*Q_W)'($signed(e3_reg.v[i]) * $signed(e3_reg.v[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg.vld <= 1'b0;
            e2_reg.vld <= 1'b0;
            e3_reg.vld <= 1'b0;
            e4_reg.vld <= 1'b0;
        end else if (adv) begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            e4_reg <= e4_next;
        end
    end

    // Squared length, modulo 2^64
    always_comb begin
        sl0_next.vld  = e4_reg.vld;
        sl0_next.v    = e4_reg.v;
        sl0_next.tir  = e4_reg.tir;
        sl0_next.rad  = e4_reg.sq[0] + e4_reg.sq[1] + e4_reg.sq[2];
        sl0_next.rem  = '0;
        sl0_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sl_reg[0].vld <= 1'b0;
        end else if (adv) begin
            sl_reg[0] <= sl0_next;
        end
    end

    // Digit-by-digit sqrt of the squared length
    for (genvar g = 1; g <= LEN_ST; g++) begin : g_len
        sl_t stage_next;
        always_comb begin
            logic [LEN_N+3:0] r;
            logic [LEN_N+3:0] trial;
            int               s;
            int               idx;
            stage_next = sl_reg[g-1];
            for (int i = 0; i < LEN_PER; i++) begin
                s = (g - 1) * LEN_PER + i;
                if (s < LEN_N) begin
                    idx   = LEN_N - 1 - s;
                    r     = {stage_next.rem, stage_next.rad[2*idx +: 2]};
                    trial = {2'b00, stage_next.root, 2'b01};
                    if (r >= trial) begin
                        r = r - trial;
                        stage_next.root = {stage_next.root[LEN_N-2:0], 1'b1};
                    end else begin
                        stage_next.root = {stage_next.root[LEN_N-2:0], 1'b0};
                    end
                    stage_next.rem = r[LEN_N+1:0];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sl_reg[g].vld <= 1'b0;
            end else if (adv) begin
                sl_reg[g] <= stage_next;
            end
        end
    end

    // Division setup: rounded numerator, overflow check, top remainder
    always_comb begin
        logic [Q_W-1:0]   mag;
        logic [OD_NW-1:0] num;
        od0_next.vld   = sl_reg[LEN_ST].vld;
        od0_next.tir   = sl_reg[LEN_ST].tir;
        od0_next.len   = sl_reg[LEN_ST].root;
        od0_next.lzero = (sl_reg[LEN_ST].root == '0);
        for (int i = 0; i < 3; i++) begin
            mag = sl_reg[LEN_ST].v[i][Q_W-1] ? Q_W'(-$signed(sl_reg[LEN_ST].v[i]))
                                             : sl_reg[LEN_ST].v[i];
            num = (OD_NW'(mag) << FRAC_BITS) + OD_NW'(sl_reg[LEN_ST].root >> 1);
            od0_next.neg[i] = sl_reg[LEN_ST].v[i][Q_W-1];
            od0_next.ovf[i] = (num >> OD_N) >= OD_NW'(sl_reg[LEN_ST].root);
            od0_next.rem[i] = LEN_N'(num >> OD_N);
            od0_next.low[i] = num[OD_N-1:0];
            od0_next.quo[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            od_reg[0].vld <= 1'b0;
        end else if (adv) begin
            od_reg[0] <= od0_next;
        end
    end

    // Per-lane restoring division by the length
    for (genvar g = 1; g <= OD_ST; g++) begin : g_odiv
        od_t stage_next;
        always_comb begin
            logic [LEN_N:0] r;
            int             j;
            stage_next = od_reg[g-1];
            for (int l = 0; l < 3; l++) begin
                for (int i = 0; i < OD_PER; i++) begin
                    j = OD_N - 1 - ((g - 1) * OD_PER + i);
                    if (j >= 0) begin
                        r = {stage_next.rem[l], stage_next.low[l][j]};
                        if (r >= {1'b0, stage_next.len}) begin
                            r = r - {1'b0, stage_next.len};
                            stage_next.quo[l][j] = 1'b1;
                        end
                        stage_next.rem[l] = r[LEN_N-1:0];
                    end
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                od_reg[g].vld <= 1'b0;
            end else if (adv) begin
                od_reg[g] <= stage_next;
            end
        end
    end

    // Clamp, sign and special cases
    always_comb begin
        logic [FLD_W:0]   q;
        logic [FLD_W-1:0] o;
        for (int i = 0; i < 3; i++) begin
            q = od_reg[OD_ST].ovf[i] ? OUT_LIM : {1'b0, od_reg[OD_ST].quo[i]};
            if (q > OUT_LIM) begin
                q = OUT_LIM;
            end
            if (od_reg[OD_ST].neg[i]) begin
                o = FLD_W'(-q);
            end else if (q > {1'b0, OUT_POS_MAX}) begin
                o = OUT_POS_MAX;
            end else begin
                o = q[FLD_W-1:0];
            end
            if (od_reg[OD_ST].tir || od_reg[OD_ST].lzero) begin
                o = '0;
            end
            m_data_next[FLD_W*i +: FLD_W] = o;
        end
        m_user_next = od_reg[OD_ST].tir;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= od_reg[OD_ST].vld;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Total reflection always carries a zero vector
    a_tir_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("total reflection with nonzero vector");

    // A held pipeline keeps its last stage
    a_hold_last: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(od_reg[OD_ST]))
        else $error("last stage changed while held");

    // A held pipeline takes no new ray
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(s1_reg))
        else $error("input stage changed while held");

    // Valid advances from the divider setup register into the first divider stage
    a_vld_move: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && ed_reg[0].vld |=> ed_reg[1].vld)
        else $error("ray lost in reciprocal divider");

endmodule

`default_nettype wire
